/* sv/plrr_pkg.sv */
// Shared types, constants and the output clamp for the pixel range rescale unit.
package plrr_pkg;

  localparam int SampleW     = 32;
  localparam int SampleBitsDef = 32;
  localparam int QuoW        = 32;
  localparam int NumW        = 66;
  localparam int MagW        = 65;
  localparam int ResW        = 34;
  localparam int IdxW        = 3;

  typedef enum logic [IdxW-1:0] {
    RegSrcLo    = 3'd0,
    RegSrcHi    = 3'd1,
    RegDstLo    = 3'd2,
    RegDstHi    = 3'd3,
    RegDestKind = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KindByte = 2'd0,
    KindS16  = 2'd1,
    KindS32  = 2'd2
  } dest_kind_e;

  localparam logic signed [ResW-1:0] ByteMin = 34'sd0;
  localparam logic signed [ResW-1:0] ByteMax = 34'sd255;
  localparam logic signed [ResW-1:0] S16Min  = -34'sd32768;
  localparam logic signed [ResW-1:0] S16Max  = 34'sd32767;
  localparam logic signed [ResW-1:0] S32Min  = -34'sd2147483648;
  localparam logic signed [ResW-1:0] S32Max  = 34'sd2147483647;
  localparam logic signed [ResW-1:0] QuoOvf  = 34'sd4294967296;

  typedef struct packed {
    logic            v;
    logic            neg;
    logic            ovf;
    logic [QuoW-1:0] rem;
    logic [QuoW-1:0] low;
    logic [QuoW-1:0] quo;
  } link_t;

  function automatic logic [31:0] clamp_kind(logic signed [ResW-1:0] val,
                                             dest_kind_e kind);
    logic signed [ResW-1:0] lo;
    logic signed [ResW-1:0] hi;
    logic signed [ResW-1:0] r;
    case (kind)
      KindByte: begin
        lo = ByteMin;
        hi = ByteMax;
      end
      KindS16: begin
        lo = S16Min;
        hi = S16Max;
      end
      default: begin
        lo = S32Min;
        hi = S32Max;
      end
    endcase
    if (val < lo) begin
      r = lo;
    end else if (val > hi) begin
      r = hi;
    end else begin
      r = val;
    end
    return r[31:0];
  endfunction

endpackage

/* sv/plrr_front.sv */
// Front pipeline: products, exact numerator, magnitude and quotient overflow check.
module plrr_front #(
  parameter int SAMPLE_BITS = plrr_pkg::SampleBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                in_v_i,
  input  logic signed [plrr_pkg::SampleW-1:0] sample_i,
  input  logic signed [31:0]                  sl_i,
  input  logic signed [31:0]                  sh_i,
  input  logic signed [31:0]                  dl_i,
  input  logic signed [31:0]                  dh_i,
  input  logic [plrr_pkg::QuoW-1:0]           d_i,
  input  logic                                den_neg_i,
  output plrr_pkg::link_t                     link_o
);

  localparam int ProdW = 33 + SAMPLE_BITS;
  localparam int NW    = plrr_pkg::NumW;
  localparam int MW    = plrr_pkg::MagW;
  localparam int QW    = plrr_pkg::QuoW;

  logic signed [32:0]          diff;
  logic signed [SAMPLE_BITS-1:0] s;
  logic signed [ProdW-1:0]     m0_d, m0_q;
  logic signed [63:0]          m1_d, m1_q, m2_d, m2_q;
  logic signed [NW-1:0]        n_d, n_q;
  logic [MW-1:0]               mag_d, mag_q;
  logic                        neg_q;
  logic                        v1_q, v2_q, v3_q, v4_q;
  plrr_pkg::link_t             link_d, link_q;

  assign diff = 33'(dh_i) - 33'(dl_i);
  assign s    = sample_i[SAMPLE_BITS-1:0];
  assign m0_d = diff * s;
  assign m1_d = dl_i * sh_i;
  assign m2_d = dh_i * sl_i;
  assign n_d  = NW'(m0_q) + NW'(m1_q) - NW'(m2_q);
  assign mag_d = n_q[NW-1] ? MW'(-n_q) : MW'(n_q);

  always_comb begin
    link_d     = '0;
    link_d.v   = v3_q;
    link_d.neg = neg_q;
    link_d.ovf = (mag_q[MW-1:QW] >= {1'b0, d_i});
    link_d.rem = mag_q[2*QW-1:QW];
    link_d.low = mag_q[QW-1:0];
    link_d.quo = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= in_v_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m0_q   <= m0_d;
      m1_q   <= m1_d;
      m2_q   <= m2_d;
      n_q    <= n_d;
      mag_q  <= mag_d;
      neg_q  <= n_q[NW-1] ^ den_neg_i;
      link_q <= link_d;
    end
  end

  always_comb begin
    link_o   = link_q;
    link_o.v = v4_q;
  end

endmodule

/* sv/plrr_cell.sv */
// One restoring-division cell: settles one quotient bit per request.
module plrr_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic [plrr_pkg::QuoW-1:0] d_i,
  input  plrr_pkg::link_t           link_i,
  output plrr_pkg::link_t           link_o
);

  localparam int QW = plrr_pkg::QuoW;

  logic [QW:0]     trial;
  logic [QW:0]     sub;
  logic            ge;
  logic            v_q;
  plrr_pkg::link_t link_d, link_q;

  assign trial = {link_i.rem, link_i.low[QW-1]};
  assign sub   = trial - {1'b0, d_i};
  assign ge    = (trial >= {1'b0, d_i});

  always_comb begin
    link_d     = link_i;
    link_d.rem = ge ? sub[QW-1:0] : trial[QW-1:0];
    link_d.low = {link_i.low[QW-2:0], 1'b0};
    link_d.quo = {link_i.quo[QW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= link_i.v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      link_q <= link_d;
    end
  end

  always_comb begin
    link_o   = link_q;
    link_o.v = v_q;
  end

endmodule

/* sv/pixel_linear_range_rescale_unit.sv */
// Top level: linear range rescale with saturation, pipelined through a divider cell chain.
// Path from input request to result valid: 4 front stages, 32 divider cells at one
// quotient bit each, one output register.
// Throughput: one request per cycle; the chain advances as a whole and stalls only
// when the output register and its skid register are both full.
// Reset (rst_ni low, asynchronous): all valid bits cleared, registers back to
// src 0..255, dst 0..255, byte clamp.
module pixel_linear_range_rescale_unit #(
  parameter int SAMPLE_BITS = plrr_pkg::SampleBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [plrr_pkg::IdxW-1:0]           cfg_idx_i,
  input  logic [31:0]                         cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [plrr_pkg::SampleW-1:0] sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [31:0]                  value_o
);

  localparam int QW = plrr_pkg::QuoW;
  localparam int RW = plrr_pkg::ResW;

  logic signed [31:0]     src_lo_q, src_hi_q, dst_lo_q, dst_hi_q;
  plrr_pkg::dest_kind_e   dest_kind_q;
  logic signed [32:0]     den;
  logic [QW-1:0]          d;
  logic                   den_neg;
  logic                   degen;
  logic                   en;
  plrr_pkg::link_t        chain [QW+1];
  plrr_pkg::link_t        last;
  logic signed [RW-1:0]   mag_s;
  logic signed [RW-1:0]   res;
  logic [31:0]            res_val;
  logic                   incoming;
  logic                   taking;
  logic                   out_v_q, skid_v_q;
  logic [31:0]            out_q, skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_lo_q    <= 32'sd0;
      src_hi_q    <= 32'sd255;
      dst_lo_q    <= 32'sd0;
      dst_hi_q    <= 32'sd255;
      dest_kind_q <= plrr_pkg::KindByte;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        plrr_pkg::RegSrcLo:    src_lo_q    <= cfg_data_i;
        plrr_pkg::RegSrcHi:    src_hi_q    <= cfg_data_i;
        plrr_pkg::RegDstLo:    dst_lo_q    <= cfg_data_i;
        plrr_pkg::RegDstHi:    dst_hi_q    <= cfg_data_i;
        plrr_pkg::RegDestKind: dest_kind_q <= plrr_pkg::dest_kind_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  assign den     = 33'(src_hi_q) - 33'(src_lo_q);
  assign den_neg = den[32];
  assign d       = den_neg ? QW'(-den) : den[QW-1:0];
  assign degen   = (den == '0) || (dst_hi_q == dst_lo_q);

  assign en         = !skid_v_q;
  assign in_ready_o = en;

  plrr_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .in_v_i    (in_valid_i),
    .sample_i  (sample_i),
    .sl_i      (src_lo_q),
    .sh_i      (src_hi_q),
    .dl_i      (dst_lo_q),
    .dh_i      (dst_hi_q),
    .d_i       (d),
    .den_neg_i (den_neg),
    .link_o    (chain[0])
  );

  for (genvar i = 0; i < QW; i++) begin : g_cell
    plrr_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .d_i    (d),
      .link_i (chain[i]),
      .link_o (chain[i+1])
    );
  end

  assign last    = chain[QW];
  assign mag_s   = last.ovf ? plrr_pkg::QuoOvf : signed'({2'b00, last.quo});
  assign res     = last.neg ? -mag_s : mag_s;
  assign res_val = degen ? plrr_pkg::clamp_kind(RW'(dst_lo_q), dest_kind_q)
                         : plrr_pkg::clamp_kind(res, dest_kind_q);

  assign incoming = en && last.v;
  assign taking   = out_v_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (taking) begin
        skid_v_q <= 1'b0;
      end
    end else if (incoming) begin
      if (out_v_q && !taking) begin
        skid_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end else if (taking) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (taking) begin
        out_q <= skid_q;
      end
    end else if (incoming) begin
      if (out_v_q && !taking) begin
        skid_q <= res_val;
      end else begin
        out_q <= res_val;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign value_o     = out_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register full while output register empty");

  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && !out_ready_i |=> skid_v_q)
    else $error("skid request dropped while output stalled");

  a_blocked_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_ready_i && !skid_v_q && last.v |=> skid_v_q)
    else $error("finished request not captured while output stalled");

endmodule

/* test/rescale_result_checker.sv */
// Result checker for the pixel range rescale unit: config shadow, prediction and compare.
`timescale 1ns / 100ps
module rescale_result_checker
  import plrr_pkg::*;
#(
  parameter int SampleBits = SampleBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [IdxW-1:0]        cfg_idx_i,
  input  logic [31:0]            cfg_data_i,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [SampleW-1:0]     sample_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic [31:0]            value_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  typedef struct {
    logic [31:0] sample;
    logic [31:0] value;
  } pixel_result_t;

  logic signed [31:0] src_lo_q;
  logic signed [31:0] src_hi_q;
  logic signed [31:0] dst_lo_q;
  logic signed [31:0] dst_hi_q;
  logic [1:0]         kind_q;
  pixel_result_t      rescaled_fifo[$];

  function automatic logic [31:0] rescale_pixel(logic [SampleW-1:0] raw);
    logic signed [SampleW-1:0] narrow;
    logic signed [69:0] s;
    logic signed [69:0] sl;
    logic signed [69:0] sh;
    logic signed [69:0] dl;
    logic signed [69:0] dh;
    logic signed [69:0] num;
    logic signed [69:0] den;
    logic signed [69:0] q;
    logic signed [69:0] lo;
    logic signed [69:0] hi;
    narrow = raw << (SampleW - SampleBits);
    narrow = narrow >>> (SampleW - SampleBits);
    s  = narrow;
    sl = src_lo_q;
    sh = src_hi_q;
    dl = dst_lo_q;
    dh = dst_hi_q;
    den = sh - sl;
    if (den == 0 || dh == dl) begin
      q = dl;
    end else begin
      num = (dh - dl) * s + dl * sh - dh * sl;
      q = num / den;
    end
    case (kind_q)
      KindByte: begin
        lo = 70'sd0;
        hi = 70'sd255;
      end
      KindS16: begin
        lo = -70'sd32768;
        hi = 70'sd32767;
      end
      default: begin
        lo = -70'sd2147483648;
        hi = 70'sd2147483647;
      end
    endcase
    if (q < lo) begin
      q = lo;
    end else if (q > hi) begin
      q = hi;
    end
    return q[31:0];
  endfunction

  task automatic report_mismatch(string note, logic [31:0] smp, logic [31:0] got,
                                 logic [31:0] want);
    $display("%0t: %s: sample %h got %h want %h", $time, note, smp, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_result_t head;
    if (!rst_ni) begin
      src_lo_q = 32'sd0;
      src_hi_q = 32'sd255;
      dst_lo_q = 32'sd0;
      dst_hi_q = 32'sd255;
      kind_q   = KindByte;
      rescaled_fifo.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (rescaled_fifo.size() == 0) begin
          report_mismatch("unexpected result", 'x, value_i, 'x);
        end else begin
          head = rescaled_fifo.pop_front();
          if (value_i !== head.value) begin
            report_mismatch("value mismatch", head.sample, value_i, head.value);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        head.sample = sample_i;
        head.value  = rescale_pixel(sample_i);
        rescaled_fifo.push_back(head);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegSrcLo:    src_lo_q = cfg_data_i;
          RegSrcHi:    src_hi_q = cfg_data_i;
          RegDstLo:    dst_lo_q = cfg_data_i;
          RegDstHi:    dst_hi_q = cfg_data_i;
          RegDestKind: kind_q   = cfg_data_i[1:0];
          default: ;
        endcase
      end
    end
    pending_o = rescaled_fifo.size();
  end

endmodule

/* test/tb_pixel_linear_range_rescale_unit.sv */
// Testbench top for the pixel range rescale unit: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module tb_pixel_linear_range_rescale_unit;
  import plrr_pkg::*;

  localparam int              SampleBits  = SampleBitsDef;
  localparam int              NumRegs     = 5;
  localparam logic [1:0]      KindUnused  = 2'd3;
  localparam logic [31:0]     Int32Min    = 32'h8000_0000;
  localparam logic [31:0]     Int32Max    = 32'h7fff_ffff;
  localparam logic [31:0]     AllOnes     = 32'hffff_ffff;
  localparam int              NumBlocks   = 24;
  localparam int              BlockItems  = 50;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [IdxW-1:0]    cfg_idx_i;
  logic [31:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [SampleW-1:0] sample_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [31:0]        value_o;
  int                 fail_count;
  int                 pending;
  int                 idle_pct;
  int                 stall_pct;

  pixel_linear_range_rescale_unit #(
    .SAMPLE_BITS(SampleBits)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sample_i   (sample_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .value_o    (value_o)
  );

  rescale_result_checker #(
    .SampleBits(SampleBits)
  ) u_result_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .sample_i    (sample_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_i     (value_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  task automatic write_reg(logic [IdxW-1:0] idx, logic [31:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_ranges(logic [31:0] sl, logic [31:0] sh, logic [31:0] dl,
                            logic [31:0] dh, logic [1:0] kind);
    write_reg(RegSrcLo, sl);
    write_reg(RegSrcHi, sh);
    write_reg(RegDstLo, dl);
    write_reg(RegDstHi, dh);
    write_reg(RegDestKind, {30'd0, kind});
  endtask

  // called on a falling edge, returns on the falling edge after the request
  task automatic send_sample(logic [31:0] smp);
    forever begin
      if ($urandom_range(99) < idle_pct) begin
        in_valid_i = 1'b0;
        @(negedge clk_i);
      end else begin
        break;
      end
    end
    in_valid_i = 1'b1;
    sample_i   = smp;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic logic [31:0] random_bound();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'($urandom_range(2000)) - 32'd1000;
      2: begin
        case ($urandom_range(3))
          0: return Int32Min;
          1: return Int32Max;
          2: return 32'd0;
          default: return AllOnes;
        endcase
      end
      3: return 32'($urandom_range(255));
      default: return 32'($urandom_range(65535)) - 32'd32768;
    endcase
  endfunction

  function automatic logic [31:0] random_sample(logic signed [31:0] a,
                                                logic signed [31:0] b);
    longint lo;
    longint hi;
    longint span;
    longint pick;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    span = hi - lo + 1;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: begin
        pick = longint'({$urandom, $urandom} & 64'h7fff_ffff_ffff_ffff) % span;
        return 32'(lo + pick);
      end
      6: return 32'(lo + longint'($urandom_range(6)) - 3);
      7: return 32'(hi + longint'($urandom_range(6)) - 3);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] sl;
    logic [31:0] sh;
    logic [31:0] dl;
    logic [31:0] dh;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = RegSrcLo;
    cfg_data_i  = 32'd0;
    in_valid_i  = 1'b0;
    sample_i    = '0;
    idle_pct    = 0;
    stall_pct   = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset ranges, byte clamp
    send_sample(32'd0);
    send_sample(32'd255);
    send_sample(32'd100);
    send_sample(AllOnes);
    send_sample(Int32Max);
    send_sample(Int32Min);
    drain();

    // full 32-bit span both sides
    set_ranges(Int32Min, Int32Max, Int32Min, Int32Max, KindS32);
    send_sample(Int32Min);
    send_sample(Int32Max);
    send_sample(32'd0);
    send_sample(AllOnes);
    drain();

    // reversed source range, unused clamp kind
    set_ranges(Int32Max, Int32Min, Int32Min, Int32Max, KindUnused);
    send_sample(Int32Min);
    send_sample(Int32Max);
    send_sample(32'd12345);
    drain();

    // huge gain, quotient far beyond 32 bits
    set_ranges(32'd0, 32'd1, Int32Min, Int32Max, KindS16);
    send_sample(Int32Max);
    send_sample(Int32Min);
    send_sample(32'd1);
    drain();

    // empty source range
    set_ranges(32'd7, 32'd7, -32'sd70000, 32'd5, KindS16);
    send_sample(32'd0);
    send_sample(32'd7);
    drain();

    // empty destination range
    set_ranges(32'd0, 32'd255, 32'd300, 32'd300, KindByte);
    send_sample(32'd3);
    drain();
    set_ranges(32'd0, 32'd255, -32'sd5, -32'sd5, KindByte);
    send_sample(32'd3);
    drain();

    // writes past the last register leave the setup alone
    for (int i = NumRegs; i < (1 << IdxW); i++) write_reg(i[IdxW-1:0], AllOnes);
    send_sample(32'd200);
    drain();

    for (int blk = 0; blk < NumBlocks; blk++) begin
      case (blk % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 58; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 58; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      sl = random_bound();
      sh = random_bound();
      dl = random_bound();
      dh = random_bound();
      if ($urandom_range(7) == 0) sh = sl;
      if ($urandom_range(7) == 0) dh = dl;
      set_ranges(sl, sh, dl, dh, 2'($urandom_range(3)));
      for (int n = 0; n < BlockItems; n++) send_sample(random_sample(sl, sh));
      drain();
    end

    stall_pct = 0;
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/plrr_pkg.sv
sv/plrr_front.sv
sv/plrr_cell.sv
sv/pixel_linear_range_rescale_unit.sv
test/rescale_result_checker.sv
test/tb_pixel_linear_range_rescale_unit.sv
